>>> rtl/core/kcto_pkg.sv
package kcto_pkg;

    // table size
    localparam int TABLE_ENTRIES = 32;
    localparam int CNT_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // action codes of an input beat
    localparam logic [2:0] ACT_REGISTER     = 3'd0;
    localparam logic [2:0] ACT_QUERY        = 3'd1;
    localparam logic [2:0] ACT_REMOVE_OWNER = 3'd2;
    localparam logic [2:0] ACT_REMOVE_ONE   = 3'd3;
    localparam logic [2:0] ACT_TICK         = 3'd4;

    // kind codes of a result beat
    localparam logic [2:0] KIND_ACK     = 3'd0;
    localparam logic [2:0] KIND_QUERY   = 3'd1;
    localparam logic [2:0] KIND_EXPIRED = 3'd2;
    localparam logic [2:0] KIND_DONE    = 3'd3;
    localparam logic [2:0] KIND_FULL    = 3'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] owner_id;
        logic [15:0] timer_id;
        logic [31:0] duration;
        logic        has_handler;
        logic [31:0] now_time;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  kind;
        logic        ready_res;
        logic [31:0] out_owner;
        logic [15:0] out_timer;
        logic        last;
    } t_out_beat;

    // one table entry held by a cell
    typedef struct packed {
        logic        valid;
        logic [31:0] owner;
        logic [15:0] timer;
        logic [31:0] end_time;
        logic        notify;
    } t_entry;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_PREV,
        CELL_NEXT,
        CELL_CLEAR
    } t_cell_op;

    // per-cell match flags
    typedef struct packed {
        logic valid;
        logic key_eq;
        logic owner_eq;
        logic key_gt;
    } t_cell_stat;

    // table summary seen by the sequencer
    typedef struct packed {
        logic        any_key_eq;
        logic        full;
        logic        compact;
        logic        head_report;
        logic [31:0] head_owner;
        logic [15:0] head_timer;
    } t_table_stat;

    // sequencer commands to the cell row
    typedef struct packed {
        logic       exec;
        logic       store;
        logic       rotate;
        logic       compact;
        logic [2:0] action;
    } t_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ROTATE,
        ST_DONE,
        ST_COMPACT
    } t_state;

endpackage

>>> rtl/core/kcto_cell.sv
module kcto_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kcto_pkg::t_cell_op i_op,
    input  kcto_pkg::t_entry  i_new,
    input  kcto_pkg::t_entry  i_prev,
    input  kcto_pkg::t_entry  i_next,
    input  logic [31:0]       i_key_owner,
    input  logic [15:0]       i_key_timer,
    output kcto_pkg::t_entry  o_entry,
    output kcto_pkg::t_cell_stat o_stat
);
    import kcto_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // pick the next content of this cell
    always_comb begin
        n_entry = r_entry;
        case (i_op)
            CELL_HOLD:  n_entry = r_entry;
            CELL_LOAD:  n_entry = i_new;
            CELL_PREV:  n_entry = i_prev;
            CELL_NEXT:  n_entry = i_next;
            CELL_CLEAR: n_entry.valid = 1'b0;
            default:    n_entry = r_entry;
        endcase
    end

    // hold the entry; reset drops only the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

    // compare against the broadcast key
    always_comb begin
        o_stat.valid    = r_entry.valid;
        o_stat.owner_eq = r_entry.valid && (r_entry.owner == i_key_owner);
        o_stat.key_eq   = o_stat.owner_eq && (r_entry.timer == i_key_timer);
        o_stat.key_gt   = {r_entry.owner, r_entry.timer} > {i_key_owner, i_key_timer};
    end

    assign o_entry = r_entry;

endmodule

>>> rtl/core/kcto_seq.sv
module kcto_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  kcto_pkg::t_in_beat    i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output kcto_pkg::t_out_beat   o_out_beat,
    input  kcto_pkg::t_table_stat i_stat,
    output kcto_pkg::t_in_beat    o_cmd,
    output kcto_pkg::t_ctrl       o_ctrl
);
    import kcto_pkg::*;

    t_state     r_state;
    t_state     n_state;
    t_in_beat   r_cmd;
    logic [CNT_W-1:0] r_cnt;
    logic       r_out_valid;
    t_out_beat  r_out;

    logic       w_out_free;
    logic       w_accept;
    logic       w_step;
    logic       w_emit;
    logic       w_last_step;
    t_out_beat  w_beat;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_step      = w_out_free || !i_stat.head_report;
    assign w_last_step = (r_cnt == CNT_W'(TABLE_ENTRIES - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in_beat.action == ACT_TICK) ? ST_ROTATE : ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_out_free) begin
                    if (r_cmd.action == ACT_REMOVE_OWNER || r_cmd.action == ACT_REMOVE_ONE) begin
                        n_state = ST_COMPACT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ROTATE: begin
                if (w_step && w_last_step) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_COMPACT;
                end
            end
            ST_COMPACT: begin
                if (i_stat.compact) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs per state
    always_comb begin
        o_in_ready     = 1'b0;
        o_ctrl.exec    = 1'b0;
        o_ctrl.rotate  = 1'b0;
        o_ctrl.compact = 1'b0;
        o_ctrl.action  = r_cmd.action;
        o_ctrl.store   = (r_cmd.duration != 32'd0) && (i_stat.any_key_eq || !i_stat.full);
        w_emit         = 1'b0;
        w_beat         = '0;
        w_beat.kind    = KIND_ACK;
        w_beat.last    = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_EXEC: begin
                o_ctrl.exec = w_out_free;
                w_emit      = w_out_free;
                if (r_cmd.action == ACT_QUERY) begin
                    w_beat.kind      = KIND_QUERY;
                    w_beat.ready_res = !i_stat.any_key_eq;
                end else if (r_cmd.action == ACT_REGISTER && r_cmd.duration != 32'd0
                             && !o_ctrl.store) begin
                    w_beat.kind = KIND_FULL;
                end
            end
            ST_ROTATE: begin
                o_ctrl.rotate    = w_step;
                w_emit           = w_step && i_stat.head_report;
                w_beat.kind      = KIND_EXPIRED;
                w_beat.out_owner = i_stat.head_owner;
                w_beat.out_timer = i_stat.head_timer;
                w_beat.last      = 1'b0;
            end
            ST_DONE: begin
                w_emit      = w_out_free;
                w_beat.kind = KIND_DONE;
            end
            ST_COMPACT: begin
                o_ctrl.compact = !i_stat.compact;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // latch the command, advance the scan count, hold the result beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_in_beat;
            r_cnt <= '0;
        end else if (o_ctrl.rotate) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (w_emit) begin
            r_out <= w_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;
    assign o_cmd       = r_cmd;

endmodule

>>> rtl/core/keyed_cooldown_timeout_table.sv
// Cooldown table of TABLE_ENTRIES entries held in a row of cells, kept
// packed toward cell 0 and sorted by (owner, timer). Register, query and
// remove beats compare against all cells at once: an item is taken in the
// idle state and its result is loaded in the exec state once the result
// register is free. A remove is followed by a compaction pass that slides
// the entries above each freed cell down by one cell per cycle. A tick
// rotates the whole row once through cell 0, dropping expired entries and
// reporting those with a handler in key order, then sends the done beat
// and compacts. The result register stalls the rotation while an expiry
// beat waits. A new item is taken only once the previous one has finished.
module keyed_cooldown_timeout_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  kcto_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output kcto_pkg::t_out_beat o_out_beat
);
    import kcto_pkg::*;

    localparam int N = TABLE_ENTRIES;

    t_in_beat    w_cmd;
    t_ctrl       w_ctrl;
    t_table_stat w_tstat;
    t_entry      w_new;
    t_entry      w_head_rot;
    t_entry      w_tail_next;
    logic        w_head_exp;

    t_entry      w_entry [N];
    t_cell_stat  w_stat  [N];
    t_cell_op    w_op    [N];
    logic [N-1:0] w_valid;
    logic [N-1:0] w_key_eq;
    logic [N-1:0] w_free_gt;
    logic [N-1:0] w_first;
    logic [N-1:0] w_hole;
    logic [N-1:0] w_gap;

    kcto_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat),
        .i_stat      (w_tstat),
        .o_cmd       (w_cmd),
        .o_ctrl      (w_ctrl)
    );

    // entry written by a register beat
    always_comb begin
        w_new.valid    = 1'b1;
        w_new.owner    = w_cmd.owner_id;
        w_new.timer    = w_cmd.timer_id;
        w_new.end_time = w_cmd.now_time + w_cmd.duration;
        w_new.notify   = w_cmd.has_handler;
    end

    // head of the row: expiry test, and the entry that wraps to the tail
    assign w_head_exp = w_entry[0].valid && (w_entry[0].end_time < w_cmd.now_time);
    always_comb begin
        w_head_rot       = w_entry[0];
        w_head_rot.valid = w_entry[0].valid && !w_head_exp;
        w_tail_next      = w_ctrl.rotate ? w_head_rot : '0;
    end

    for (genvar gi = 0; gi < N; gi++) begin : g_cell
        assign w_valid[gi]   = w_stat[gi].valid;
        assign w_key_eq[gi]  = w_stat[gi].key_eq;
        assign w_free_gt[gi] = !w_stat[gi].valid || w_stat[gi].key_gt;

        // insert point, and cells at or above the first hole
        if (gi == 0) begin : g_first
            assign w_first[gi] = w_free_gt[gi];
            assign w_hole[gi]  = !w_valid[gi];
        end else begin : g_rest
            assign w_first[gi] = w_free_gt[gi] && !w_free_gt[gi-1];
            assign w_hole[gi]  = w_hole[gi-1] || !w_valid[gi];
        end

        // valid entry right above a free cell
        if (gi == N - 1) begin : g_gap_end
            assign w_gap[gi] = 1'b0;
        end else begin : g_gap
            assign w_gap[gi] = !w_valid[gi] && w_valid[gi+1];
        end

        // decode the cell operation
        always_comb begin
            w_op[gi] = CELL_HOLD;
            if (w_ctrl.rotate) begin
                w_op[gi] = CELL_NEXT;
            end else if (w_ctrl.compact) begin
                w_op[gi] = w_hole[gi] ? CELL_NEXT : CELL_HOLD;
            end else if (w_ctrl.exec) begin
                case (w_ctrl.action)
                    ACT_REGISTER: begin
                        if (w_ctrl.store) begin
                            if (w_tstat.any_key_eq) begin
                                w_op[gi] = w_key_eq[gi] ? CELL_LOAD : CELL_HOLD;
                            end else if (w_first[gi]) begin
                                w_op[gi] = CELL_LOAD;
                            end else if (w_free_gt[gi]) begin
                                w_op[gi] = CELL_PREV;
                            end
                        end
                    end
                    ACT_REMOVE_OWNER: begin
                        if (w_stat[gi].owner_eq) w_op[gi] = CELL_CLEAR;
                    end
                    ACT_REMOVE_ONE: begin
                        if (w_key_eq[gi]) w_op[gi] = CELL_CLEAR;
                    end
                    default: w_op[gi] = CELL_HOLD;
                endcase
            end
        end

        kcto_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_op        (w_op[gi]),
            .i_new       (w_new),
            .i_prev      (w_entry[(gi + N - 1) % N]),
            .i_next      ((gi == N - 1) ? w_tail_next : w_entry[(gi + 1) % N]),
            .i_key_owner (w_cmd.owner_id),
            .i_key_timer (w_cmd.timer_id),
            .o_entry     (w_entry[gi]),
            .o_stat      (w_stat[gi])
        );
    end

    // summary for the sequencer
    always_comb begin
        w_tstat.any_key_eq  = |w_key_eq;
        w_tstat.full        = w_valid[N-1];
        w_tstat.compact     = !(|w_gap);
        w_tstat.head_report = w_head_exp && w_entry[0].notify;
        w_tstat.head_owner  = w_entry[0].owner;
        w_tstat.head_timer  = w_entry[0].timer;
    end

endmodule

>>> verif/tb_keyed_cooldown_timeout_table.sv
`timescale 1ns / 100ps

module tb_keyed_cooldown_timeout_table;

    import kcto_pkg::*;

    // action codes the block treats as no-ops
    localparam logic [2:0] ACT_RSVD5 = 3'd5;
    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;

    // one row of the directed table: request and, where typed, its single answer
    typedef struct packed {
        t_in_beat  req;
        logic      typed;
        t_out_beat res;
    } t_dir_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_beat out_beat;

    // shadow of the cooldown table
    logic        tbl_used   [TABLE_ENTRIES];
    logic [31:0] tbl_owner  [TABLE_ENTRIES];
    logic [15:0] tbl_timer  [TABLE_ENTRIES];
    logic [31:0] tbl_end    [TABLE_ENTRIES];
    logic        tbl_notify [TABLE_ENTRIES];

    // answers of the latest request, then the queue of answers still owed
    t_out_beat step_out [TABLE_ENTRIES + 1];
    int        step_cnt;
    t_out_beat due_results [$];
    t_dir_row  dir_tab [$];

    int fail_cnt      = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int hold_left     = 0;

    logic [31:0] owner_pool [4];
    logic [15:0] timer_pool [12];

    keyed_cooldown_timeout_table dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // end the run if it hangs
    initial begin
        #(6_000_000);
        $display("Mismatches found");
        $finish;
    end

    function automatic t_dir_row mk_row(input logic [2:0] act, input logic [31:0] owner,
                                        input logic [15:0] timer, input logic [31:0] dur,
                                        input logic hdl, input logic [31:0] now,
                                        input logic typed, input logic [2:0] kind,
                                        input logic rdy);
        t_dir_row r;
        r = '0;
        r.req.action      = act;
        r.req.owner_id    = owner;
        r.req.timer_id    = timer;
        r.req.duration    = dur;
        r.req.has_handler = hdl;
        r.req.now_time    = now;
        r.typed           = typed;
        r.res.kind        = kind;
        r.res.ready_res   = rdy;
        r.res.last        = 1'b1;
        return r;
    endfunction

    function automatic int lookup_slot(input logic [31:0] owner, input logic [15:0] timer);
        int slot;
        slot = -1;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
            if (tbl_used[i] && tbl_owner[i] == owner && tbl_timer[i] == timer) slot = i;
        return slot;
    endfunction

    task automatic push_step(input logic [2:0] kind, input logic rdy, input logic [31:0] owner,
                             input logic [15:0] timer, input logic last);
        step_out[step_cnt].kind      = kind;
        step_out[step_cnt].ready_res = rdy;
        step_out[step_cnt].out_owner = owner;
        step_out[step_cnt].out_timer = timer;
        step_out[step_cnt].last      = last;
        step_cnt++;
    endtask

    // apply one request to the shadow table and list the answers it causes
    task automatic step_table(input t_in_beat b);
        int         slot;
        int         pick;
        logic [2:0] kind;
        logic       expired [TABLE_ENTRIES];
        step_cnt = 0;
        case (b.action)
            ACT_REGISTER: begin
                kind = KIND_ACK;
                if (b.duration != 32'd0) begin
                    slot = lookup_slot(b.owner_id, b.timer_id);
                    // take the lowest free cell for a new key
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (slot < 0 && !tbl_used[i]) slot = i;
                    if (slot < 0) begin
                        kind = KIND_FULL;
                    end else begin
                        tbl_used[slot]   = 1'b1;
                        tbl_owner[slot]  = b.owner_id;
                        tbl_timer[slot]  = b.timer_id;
                        tbl_end[slot]    = b.now_time + b.duration;
                        tbl_notify[slot] = b.has_handler;
                    end
                end
                push_step(kind, 1'b0, 32'd0, 16'd0, 1'b1);
            end
            ACT_QUERY: begin
                push_step(KIND_QUERY, lookup_slot(b.owner_id, b.timer_id) < 0,
                          32'd0, 16'd0, 1'b1);
            end
            ACT_REMOVE_OWNER: begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (tbl_owner[i] == b.owner_id) tbl_used[i] = 1'b0;
                push_step(KIND_ACK, 1'b0, 32'd0, 16'd0, 1'b1);
            end
            ACT_REMOVE_ONE: begin
                slot = lookup_slot(b.owner_id, b.timer_id);
                if (slot >= 0) tbl_used[slot] = 1'b0;
                push_step(KIND_ACK, 1'b0, 32'd0, 16'd0, 1'b1);
            end
            ACT_TICK: begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    expired[i] = tbl_used[i] && (tbl_end[i] < b.now_time);
                // drop expired entries smallest key first, report those with a handler
                pick = 0;
                while (pick >= 0) begin
                    pick = -1;
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (expired[i] && (pick < 0 || tbl_owner[i] < tbl_owner[pick] ||
                            (tbl_owner[i] == tbl_owner[pick] && tbl_timer[i] < tbl_timer[pick])))
                            pick = i;
                    if (pick >= 0) begin
                        expired[pick]  = 1'b0;
                        tbl_used[pick] = 1'b0;
                        if (tbl_notify[pick])
                            push_step(KIND_EXPIRED, 1'b0, tbl_owner[pick], tbl_timer[pick], 1'b0);
                    end
                end
                push_step(KIND_DONE, 1'b0, 32'd0, 16'd0, 1'b1);
            end
            default: begin
                push_step(KIND_ACK, 1'b0, 32'd0, 16'd0, 1'b1);
            end
        endcase
    endtask

    // offer one request beat, hold it until taken, then queue its answers
    task automatic offer_beat(input t_in_beat b, input logic typed, input t_out_beat typed_res);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        step_table(b);
        if (typed) begin
            due_results.push_back(typed_res);
        end else begin
            for (int i = 0; i < step_cnt; i++) due_results.push_back(step_out[i]);
        end
    endtask

    task automatic check_result(input t_out_beat got);
        t_out_beat want;
        if (due_results.size() == 0) begin
            $error("result beat with nothing expected: kind %0d", got.kind);
            fail_cnt++;
        end else begin
            want = due_results.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                fail_cnt++;
            end
            if (got.ready_res !== want.ready_res) begin
                $error("ready_res: expected %0d, got %0d", want.ready_res, got.ready_res);
                fail_cnt++;
            end
            if (got.out_owner !== want.out_owner) begin
                $error("out_owner: expected %h, got %h", want.out_owner, got.out_owner);
                fail_cnt++;
            end
            if (got.out_timer !== want.out_timer) begin
                $error("out_timer: expected %h, got %h", want.out_timer, got.out_timer);
                fail_cnt++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                fail_cnt++;
            end
        end
    endtask

    // check result beats and drive ready, with an occasional long hold-off
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_ready) check_result(out_beat);
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        t_in_beat    req;
        int          roll;
        int          key;
        int          base;
        int          drain;
        logic [31:0] now_s;

        for (int i = 0; i < TABLE_ENTRIES; i++) tbl_used[i] = 1'b0;

        // directed table: act, owner, timer, duration, handler, now, typed, kind, ready
        dir_tab.push_back(mk_row(ACT_QUERY, 32'd0, 16'd0, 32'd0, 1'b0, 32'd0,
                                 1'b1, KIND_QUERY, 1'b1));
        dir_tab.push_back(mk_row(ACT_REGISTER, 32'd0, 16'd0, 32'd0, 1'b1, 32'd0,
                                 1'b1, KIND_ACK, 1'b0));
        dir_tab.push_back(mk_row(ACT_QUERY, 32'd0, 16'd0, 32'd0, 1'b0, 32'd0,
                                 1'b1, KIND_QUERY, 1'b1));
        dir_tab.push_back(mk_row(ACT_REGISTER, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                                 32'd0, 1'b1, KIND_ACK, 1'b0));
        dir_tab.push_back(mk_row(ACT_QUERY, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 1'b0, 32'd0,
                                 1'b1, KIND_QUERY, 1'b0));
        // end time wraps past zero
        dir_tab.push_back(mk_row(ACT_REGISTER, 32'd0, 16'd0, 32'h20, 1'b1, 32'hFFFF_FFF0,
                                 1'b1, KIND_ACK, 1'b0));
        dir_tab.push_back(mk_row(ACT_REGISTER, 32'd5, 16'd3, 32'd100, 1'b0, 32'd0,
                                 1'b1, KIND_ACK, 1'b0));
        // overwrite an existing key in place
        dir_tab.push_back(mk_row(ACT_REGISTER, 32'd5, 16'd3, 32'd5, 1'b1, 32'd0,
                                 1'b1, KIND_ACK, 1'b0));
        dir_tab.push_back(mk_row(ACT_REGISTER, 32'd5, 16'd1, 32'd2, 1'b1, 32'd0,
                                 1'b0, KIND_ACK, 1'b0));
        dir_tab.push_back(mk_row(ACT_REGISTER, 32'd2, 16'd7, 32'd3, 1'b0, 32'd0,
                                 1'b0, KIND_ACK, 1'b0));
        dir_tab.push_back(mk_row(ACT_TICK, 32'd0, 16'd0, 32'd0, 1'b0, 32'd0,
                                 1'b1, KIND_DONE, 1'b0));
        dir_tab.push_back(mk_row(ACT_TICK, 32'd0, 16'd0, 32'd0, 1'b0, 32'h100,
                                 1'b0, KIND_DONE, 1'b0));
        dir_tab.push_back(mk_row(ACT_QUERY, 32'd5, 16'd3, 32'd0, 1'b0, 32'd0,
                                 1'b0, KIND_QUERY, 1'b0));
        // removes of an absent key and an absent owner
        dir_tab.push_back(mk_row(ACT_REMOVE_ONE, 32'd9, 16'd9, 32'd0, 1'b0, 32'd0,
                                 1'b1, KIND_ACK, 1'b0));
        dir_tab.push_back(mk_row(ACT_REMOVE_OWNER, 32'h1234_5678, 16'd0, 32'd0, 1'b0, 32'd0,
                                 1'b1, KIND_ACK, 1'b0));
        dir_tab.push_back(mk_row(ACT_REGISTER, 32'd7, 16'd1, 32'd50, 1'b1, 32'h100,
                                 1'b0, KIND_ACK, 1'b0));
        dir_tab.push_back(mk_row(ACT_REGISTER, 32'd7, 16'd2, 32'd60, 1'b1, 32'h100,
                                 1'b0, KIND_ACK, 1'b0));
        dir_tab.push_back(mk_row(ACT_REMOVE_ONE, 32'd7, 16'd1, 32'd0, 1'b0, 32'd0,
                                 1'b1, KIND_ACK, 1'b0));
        dir_tab.push_back(mk_row(ACT_REMOVE_OWNER, 32'd7, 16'd0, 32'd0, 1'b0, 32'd0,
                                 1'b1, KIND_ACK, 1'b0));
        dir_tab.push_back(mk_row(ACT_QUERY, 32'd7, 16'd2, 32'd0, 1'b0, 32'd0,
                                 1'b0, KIND_QUERY, 1'b0));
        dir_tab.push_back(mk_row(ACT_REGISTER, 32'hFFFF_FFFF, 16'd0, 32'd1, 1'b1, 32'hFFFF_FFFD,
                                 1'b0, KIND_ACK, 1'b0));
        // unused action codes only acknowledge
        dir_tab.push_back(mk_row(ACT_RSVD5, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                                 32'hFFFF_FFFF, 1'b1, KIND_ACK, 1'b0));
        dir_tab.push_back(mk_row(ACT_RSVD6, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                                 32'hFFFF_FFFF, 1'b1, KIND_ACK, 1'b0));
        dir_tab.push_back(mk_row(ACT_RSVD7, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                                 32'hFFFF_FFFF, 1'b1, KIND_ACK, 1'b0));
        dir_tab.push_back(mk_row(ACT_TICK, 32'd0, 16'd0, 32'd0, 1'b0, 32'hFFFF_FFFF,
                                 1'b0, KIND_DONE, 1'b0));

        // hold reset, then release
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 13;
        recv_idle_pct = 13;
        foreach (dir_tab[i]) offer_beat(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);

        // random part: one idling pattern per phase
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_req      = 400;
                end
                1: begin
                    send_idle_pct = 57;
                    recv_idle_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 57;
                end
                default: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 13;
                end
            endcase

            // small key pool so keys collide and the table fills
            owner_pool[0] = (phase == 0) ? 32'd0 : $urandom;
            owner_pool[1] = 32'hFFFF_FFFF;
            owner_pool[2] = $urandom;
            owner_pool[3] = $urandom;
            for (int i = 0; i < 12; i++) timer_pool[i] = 16'($urandom_range(0, 65535));
            timer_pool[11] = 16'hFFFF;
            now_s = (phase == 3) ? 32'hFFFF_FF00 : 32'($urandom_range(0, 5000));

            // fill past capacity with distinct keys, overwrite one while full, expire all
            if (phase == 0) begin
                base = $urandom_range(0, 47);
                for (int k = 0; k <= TABLE_ENTRIES + 2; k++) begin
                    key = (k == TABLE_ENTRIES + 2) ? base : (k * 7 + base) % 48;
                    req             = '0;
                    req.action      = ACT_REGISTER;
                    req.owner_id    = owner_pool[key % 4];
                    req.timer_id    = timer_pool[key / 4];
                    req.duration    = 32'($urandom_range(1, 8));
                    req.has_handler = ($urandom_range(0, 7) != 0);
                    req.now_time    = now_s;
                    offer_beat(req, 1'b0, '0);
                end
                req          = '0;
                req.action   = ACT_TICK;
                req.now_time = now_s + 32'd20;
                offer_beat(req, 1'b0, '0);
            end

            for (int n = 0; n < 10; n++) begin
                req             = '0;
                req.owner_id    = owner_pool[$urandom_range(0, 3)];
                req.timer_id    = timer_pool[$urandom_range(0, 11)];
                req.has_handler = 1'($urandom_range(0, 1));
                req.now_time    = now_s;
                roll            = $urandom_range(0, 19);
                req.duration    = (roll == 0) ? 32'd0 :
                                  (roll < 3) ? $urandom : 32'($urandom_range(1, 40));
                roll = $urandom_range(0, 99);
                if (roll < 40) begin
                    req.action = ACT_REGISTER;
                end else if (roll < 55) begin
                    req.action = ACT_QUERY;
                end else if (roll < 63) begin
                    req.action = ACT_REMOVE_ONE;
                end else if (roll < 68) begin
                    req.action = ACT_REMOVE_OWNER;
                end else if (roll < 85) begin
                    // advance the clock before the tick
                    now_s        = now_s + 32'($urandom_range(0, 25));
                    req.action   = ACT_TICK;
                    req.now_time = now_s;
                end else if (roll < 90) begin
                    case ($urandom_range(0, 2))
                        0: req.action = ACT_RSVD5;
                        1: req.action = ACT_RSVD6;
                        default: req.action = ACT_RSVD7;
                    endcase
                end else begin
                    // noise: every field random
                    req.action      = 3'($urandom_range(0, 7));
                    req.owner_id    = $urandom;
                    req.timer_id    = 16'($urandom_range(0, 65535));
                    req.duration    = $urandom;
                    req.has_handler = 1'($urandom_range(0, 1));
                    req.now_time    = $urandom;
                end
                offer_beat(req, 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        // drain the owed answers, then let compaction settle
        drain = 0;
        while (due_results.size() != 0 && drain < 200000) begin
            @(posedge clk);
            drain++;
        end
        repeat (80) @(posedge clk);
        if (due_results.size() != 0) begin
            $error("%0d result beats never arrived", due_results.size());
            fail_cnt++;
        end

        if (fail_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
